@@ hw/rtl/saes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saes_pkg
// Types, constants and nibble-level functions shared by the 16-bit cipher.
// ----------------------------------------------------------------------------
package saes_pkg;

	localparam int unsigned BlockW = 16;
	localparam int unsigned KeyW   = 16;
	localparam int unsigned DataW  = 32;
	localparam int unsigned AddrW  = 3;

	localparam logic CFG_IDX_CIPHER_KEY = 1'b0;

	localparam logic KIND_ENCRYPT = 1'b0;
	localparam logic KIND_DECRYPT = 1'b1;

	localparam logic [4:0] GF_POLY   = 5'b10011;
	localparam logic [7:0] RCON1     = 8'b10000000;
	localparam logic [7:0] RCON2     = 8'b00110000;
	localparam logic [3:0] MIX_DIAG  = 4'h1;
	localparam logic [3:0] MIX_OFF   = 4'h4;
	localparam logic [3:0] IMIX_DIAG = 4'h9;
	localparam logic [3:0] IMIX_OFF  = 4'h2;

	typedef struct packed {
		logic [KeyW-1:0] k0;
		logic [KeyW-1:0] k1;
		logic [KeyW-1:0] k2;
	} saes_keys_t;

	function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
		logic [3:0] r;
		case (n)
			4'h0: r = 4'h9;
			4'h1: r = 4'h4;
			4'h2: r = 4'hA;
			4'h3: r = 4'hB;
			4'h4: r = 4'hD;
			4'h5: r = 4'h1;
			4'h6: r = 4'h8;
			4'h7: r = 4'h5;
			4'h8: r = 4'h6;
			4'h9: r = 4'h2;
			4'hA: r = 4'h0;
			4'hB: r = 4'h3;
			4'hC: r = 4'hC;
			4'hD: r = 4'hE;
			4'hE: r = 4'hF;
			4'hF: r = 4'h7;
			default: r = 4'h0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] sbox_inv(input logic [3:0] n);
		logic [3:0] r;
		case (n)
			4'h0: r = 4'hA;
			4'h1: r = 4'h5;
			4'h2: r = 4'h9;
			4'h3: r = 4'hB;
			4'h4: r = 4'h1;
			4'h5: r = 4'h7;
			4'h6: r = 4'h8;
			4'h7: r = 4'hF;
			4'h8: r = 4'h6;
			4'h9: r = 4'h0;
			4'hA: r = 4'h2;
			4'hB: r = 4'h3;
			4'hC: r = 4'hC;
			4'hD: r = 4'h4;
			4'hE: r = 4'hD;
			4'hF: r = 4'hE;
			default: r = 4'h0;
		endcase
		return r;
	endfunction

	function automatic logic [BlockW-1:0] sub_fwd(input logic [BlockW-1:0] v);
		return {sbox_fwd(v[15:12]), sbox_fwd(v[11:8]), sbox_fwd(v[7:4]), sbox_fwd(v[3:0])};
	endfunction

	function automatic logic [BlockW-1:0] sub_inv(input logic [BlockW-1:0] v);
		return {sbox_inv(v[15:12]), sbox_inv(v[11:8]), sbox_inv(v[7:4]), sbox_inv(v[3:0])};
	endfunction

	function automatic logic [BlockW-1:0] swap_row(input logic [BlockW-1:0] v);
		return {v[15:12], v[3:0], v[7:4], v[11:8]};
	endfunction

	function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
		logic [4:0] acc;
		logic [3:0] p;
		acc = {1'b0, a};
		p   = 4'h0;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) begin
				p = p ^ acc[3:0];
			end
			acc = {acc[3:0], 1'b0};
			if (acc[4]) begin
				acc = acc ^ GF_POLY;
			end
		end
		return p;
	endfunction

	function automatic logic [BlockW-1:0] mix_cols(input logic [BlockW-1:0] v,
			input logic [3:0] diag, input logic [3:0] off);
		logic [3:0] m0, m1, m2, m3;
		m0 = gf_mul(v[15:12], diag) ^ gf_mul(v[11:8], off);
		m1 = gf_mul(v[15:12], off) ^ gf_mul(v[11:8], diag);
		m2 = gf_mul(v[7:4], diag) ^ gf_mul(v[3:0], off);
		m3 = gf_mul(v[7:4], off) ^ gf_mul(v[3:0], diag);
		return {m0, m1, m2, m3};
	endfunction

	function automatic logic [7:0] sub_rot_byte(input logic [7:0] w);
		return {sbox_fwd(w[3:0]), sbox_fwd(w[7:4])};
	endfunction

	function automatic saes_keys_t expand_key(input logic [KeyW-1:0] k);
		saes_keys_t ks;
		logic [7:0] w2, w3, w4, w5;
		w2 = k[15:8] ^ RCON1 ^ sub_rot_byte(k[7:0]);
		w3 = w2 ^ k[7:0];
		w4 = w2 ^ RCON2 ^ sub_rot_byte(w3);
		w5 = w4 ^ w3;
		ks.k0 = k;
		ks.k1 = {w2, w3};
		ks.k2 = {w4, w5};
		return ks;
	endfunction

endpackage

@@ hw/rtl/saes_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saes_ifs
// Valid/ready channels for cipher requests and cipher results.
// ----------------------------------------------------------------------------
interface saes_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] data_in;

	modport source (output valid, output kind, output data_in, input ready);
	modport sink (input valid, input kind, input data_in, output ready);
endinterface

interface saes_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] data_out;

	modport source (output valid, output data_out, input ready);
	modport sink (input valid, input data_out, output ready);
endinterface

@@ hw/rtl/saes_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saes_pipe
// Three-stage cipher datapath with per-stage valid bits and ready chaining.
// ----------------------------------------------------------------------------
module saes_pipe
	import saes_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  saes_keys_t keys,
	saes_req_if.sink   req,
	saes_rsp_if.source rsp
);

	logic              valid_s1, valid_s2, valid_s3;
	logic              kind_s1, kind_s2;
	logic [BlockW-1:0] data_s1, data_s2, data_s3;
	logic              ready_s1, ready_s2, ready_s3;
	logic [BlockW-1:0] nxt_s1, nxt_s2, nxt_s3;

	assign ready_s3  = !valid_s3 || rsp.ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign req.ready = ready_s1;

	always_comb begin
		if (req.kind == KIND_DECRYPT) begin
			nxt_s1 = sub_inv(swap_row(req.data_in ^ keys.k2)) ^ keys.k1;
		end else begin
			nxt_s1 = swap_row(sub_fwd(req.data_in ^ keys.k0));
		end
	end

	always_comb begin
		if (kind_s1 == KIND_DECRYPT) begin
			nxt_s2 = mix_cols(data_s1, IMIX_DIAG, IMIX_OFF);
		end else begin
			nxt_s2 = mix_cols(data_s1, MIX_DIAG, MIX_OFF) ^ keys.k1;
		end
	end

	always_comb begin
		if (kind_s2 == KIND_DECRYPT) begin
			nxt_s3 = sub_inv(swap_row(data_s2)) ^ keys.k0;
		end else begin
			nxt_s3 = swap_row(sub_fwd(data_s2)) ^ keys.k2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= req.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && req.valid) begin
			kind_s1 <= req.kind;
			data_s1 <= nxt_s1;
		end
		if (ready_s2 && valid_s1) begin
			kind_s2 <= kind_s1;
			data_s2 <= nxt_s2;
		end
		if (ready_s3 && valid_s2) begin
			data_s3 <= nxt_s3;
		end
	end

	assign rsp.valid    = valid_s3;
	assign rsp.data_out = data_s3;

	// An empty output stage means the whole chain can take a transaction.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s3 |-> req.ready)
		else $error("input not ready although output stage is empty");

	a_accept_lands_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted transaction did not reach stage one");

	a_s2_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && valid_s3 && !rsp.ready |=> valid_s2 && $stable(data_s2))
		else $error("stage two lost or changed data during a stall");

endmodule

@@ hw/rtl/simplified_aes_block_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplified_aes_block_cipher
// 16-bit block cipher with an APB key register and a three-stage pipeline.
//
// Channel   Direction  Payload            Notes
// req       in         kind, data_in      kind 0 encrypts, 1 decrypts
// rsp       out        data_out           one result per request, in order
// APB       in/out     cipher_key @ 0x0   write-only effect, reads back key
//
// One transaction per cycle is accepted while the output is not stalled; each
// request passes through the three datapath stages in order, and its result is
// offered from the third stage register.
// Round keys are expanded once when the key register is written.
// Reset clears all stage valid bits and loads the round keys of key zero.
// A stalled output backs up stage by stage; empty stages still fill.
// ----------------------------------------------------------------------------
module simplified_aes_block_cipher
	import saes_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	saes_req_if.sink         req,
	saes_rsp_if.source       rsp
);

	saes_keys_t keys_q;
	saes_keys_t keys_ref;
	logic       key_wr;

	assign pready = 1'b1;
	assign key_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_CIPHER_KEY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= expand_key({KeyW{1'b0}});
		end else if (key_wr) begin
			keys_q <= expand_key(pwdata[KeyW-1:0]);
		end
	end

	always_comb begin
		if (paddr[2] == CFG_IDX_CIPHER_KEY) begin
			prdata = {{(DataW-KeyW){1'b0}}, keys_q.k0};
		end else begin
			prdata = '0;
		end
	end

	saes_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.keys   (keys_q),
		.req    (req),
		.rsp    (rsp)
	);

	assign keys_ref = expand_key(keys_q.k0);

	a_key_written: assert property (@(posedge clk) disable iff (!arst_n)
		key_wr |=> keys_q.k0 == $past(pwdata[KeyW-1:0]))
		else $error("cipher key register not updated by write");

	a_round_key1: assert property (@(posedge clk) disable iff (!arst_n)
		keys_q.k1 == keys_ref.k1)
		else $error("first round key out of step with cipher key");

	a_round_key2: assert property (@(posedge clk) disable iff (!arst_n)
		keys_q.k2 == keys_ref.k2)
		else $error("second round key out of step with cipher key");

endmodule

@@ tb/sv/tb_simplified_aes_block_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simplified_aes_block_cipher
// Self-checking bench for the 16-bit cipher. A behavioral cipher predicts every
// result from the key last written over APB, and results are matched in order
// against the output channel. Directed blocks and keys come first, then random
// encrypt and decrypt traffic under a series of random keys. Both channels
// stall at random, with one phase that runs without stalls.
// ----------------------------------------------------------------------------
module tb_simplified_aes_block_cipher;
	import saes_pkg::*;

	typedef struct packed {
		logic              kind;
		logic [BlockW-1:0] data;
	} cipher_req_t;

	localparam logic [AddrW-1:0] KEY_ADDR   = AddrW'(4 * CFG_IDX_CIPHER_KEY);
	localparam logic [AddrW-1:0] SPARE_ADDR = AddrW'(4 * (CFG_IDX_CIPHER_KEY + 1));

	// Substitution tables, entry i in nibble i.
	localparam logic [63:0] SUBST_FWD = 64'h7FEC_3026_581D_BA49;
	localparam logic [63:0] SUBST_INV = 64'hED4C_3206_F871_B95A;
	localparam logic [7:0]  ROUND_C1  = 8'h80;
	localparam logic [7:0]  ROUND_C2  = 8'h30;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	saes_req_if req_ch ();
	saes_rsp_if rsp_ch ();

	cipher_req_t       pending_q[$];
	logic [BlockW-1:0] expected_q[$];
	logic [KeyW-1:0]   key_copy;
	logic              steady;
	int unsigned       errors;

	simplified_aes_block_cipher i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	function automatic logic [15:0] subst_nibbles(input logic [15:0] v, input logic [63:0] box);
		logic [15:0] r;
		for (int s = 0; s < 4; s++) begin
			r[4*s +: 4] = box[4*v[4*s +: 4] +: 4];
		end
		return r;
	endfunction

	function automatic logic [15:0] row_swap(input logic [15:0] v);
		return (v & 16'hF0F0) | {8'h00, 4'h0, v[11:8]} | {4'h0, v[3:0], 8'h00};
	endfunction

	function automatic logic [3:0] gf16_times(input logic [3:0] a, input logic [3:0] b);
		logic [3:0] prod;
		logic [3:0] x;
		prod = 4'h0;
		x = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) begin
				prod = prod ^ x;
			end
			x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
		end
		return prod;
	endfunction

	function automatic logic [15:0] column_mix(input logic [15:0] v, input logic [3:0] d,
			input logic [3:0] o);
		return {gf16_times(v[15:12], d) ^ gf16_times(v[11:8], o),
			gf16_times(v[15:12], o) ^ gf16_times(v[11:8], d),
			gf16_times(v[7:4], d) ^ gf16_times(v[3:0], o),
			gf16_times(v[7:4], o) ^ gf16_times(v[3:0], d)};
	endfunction

	function automatic logic [7:0] rot_subst(input logic [7:0] w);
		return {SUBST_FWD[4*w[3:0] +: 4], SUBST_FWD[4*w[7:4] +: 4]};
	endfunction

	function automatic logic [15:0] cipher_block(input logic [15:0] key, input logic kind,
			input logic [15:0] blk);
		logic [7:0]  w2, w3, w4, w5;
		logic [15:0] rk1, rk2, x;
		w2 = key[15:8] ^ ROUND_C1 ^ rot_subst(key[7:0]);
		w3 = w2 ^ key[7:0];
		w4 = w2 ^ ROUND_C2 ^ rot_subst(w3);
		w5 = w4 ^ w3;
		rk1 = {w2, w3};
		rk2 = {w4, w5};
		if (kind == KIND_ENCRYPT) begin
			x = blk ^ key;
			x = row_swap(subst_nibbles(x, SUBST_FWD));
			x = column_mix(x, 4'h1, 4'h4) ^ rk1;
			x = row_swap(subst_nibbles(x, SUBST_FWD)) ^ rk2;
		end else begin
			x = blk ^ rk2;
			x = subst_nibbles(row_swap(x), SUBST_INV) ^ rk1;
			x = column_mix(x, 4'h9, 4'h2);
			x = subst_nibbles(row_swap(x), SUBST_INV) ^ key;
		end
		return x;
	endfunction

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Request driver: holds a block until it is taken, then presents the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_q.push_back(cipher_block(key_copy, req_ch.kind, req_ch.data_in));
				pending_q.delete(0);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_q.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
					req_ch.valid   <= 1'b1;
					req_ch.kind    <= pending_q[0].kind;
					req_ch.data_in <= pending_q[0].data;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every transaction must match the oldest outstanding block.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h",
						$time, rsp_ch.data_out);
				end else begin
					if (rsp_ch.data_out !== expected_q[0]) begin
						errors++;
						$display("%0t: data_out mismatch, expected %h, actual %h",
							$time, expected_q[0], rsp_ch.data_out);
					end
					expected_q.delete(0);
				end
			end
			rsp_ch.ready <= steady || ($urandom_range(99) >= 25);
		end
	end

	task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == KEY_ADDR) begin
			key_copy = value[KeyW-1:0];
		end
	endtask

	task automatic apb_check_key();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= KEY_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[KeyW-1:0] !== key_copy) begin
			errors++;
			$display("%0t: key readback mismatch, expected %h, actual %h",
				$time, key_copy, prdata[KeyW-1:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_block(input logic kind, input logic [BlockW-1:0] data);
		cipher_req_t item;
		item.kind = kind;
		item.data = data;
		pending_q.push_back(item);
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || expected_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [15:0] corner[4];
		int          calm_phase;
		clk            = 1'b0;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_ch.valid   = 1'b0;
		req_ch.kind    = KIND_ENCRYPT;
		req_ch.data_in = '0;
		rsp_ch.ready   = 1'b0;
		key_copy       = '0;
		steady         = 1'b0;
		errors         = 0;
		corner         = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
		calm_phase     = $urandom_range(7);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Key after reset is zero.
		apb_check_key();
		@(negedge clk);
		foreach (corner[i]) begin
			add_block(KIND_ENCRYPT, corner[i]);
			add_block(KIND_DECRYPT, corner[i]);
		end
		drain();

		// Textbook key with stray upper data bits, which must be ignored.
		apb_write(KEY_ADDR, {16'hDEAD, 16'hA73B});
		apb_check_key();
		@(negedge clk);
		add_block(KIND_ENCRYPT, 16'h6F6B);
		add_block(KIND_DECRYPT, 16'h0738);
		add_block(KIND_ENCRYPT, 16'hFFFF);
		add_block(KIND_DECRYPT, 16'h0000);
		drain();

		// A write past the register list leaves the key alone.
		apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
		apb_write(KEY_ADDR, 32'h0000_FFFF);
		apb_check_key();
		@(negedge clk);
		add_block(KIND_ENCRYPT, 16'h0000);
		add_block(KIND_DECRYPT, 16'hFFFF);
		add_block(KIND_ENCRYPT, 16'h8001);
		add_block(KIND_DECRYPT, 16'h7FFE);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			apb_write(SPARE_ADDR, $urandom());
			apb_write(KEY_ADDR, $urandom());
			apb_check_key();
			@(negedge clk);
			steady = (phase == calm_phase);
			repeat (105) begin
				add_block(1'($urandom_range(1)), BlockW'($urandom_range(16'hFFFF)));
			end
			drain();
			steady = 1'b0;
		end

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
